// ----- design/dbed_pkg.sv -----
package dbed_pkg;

    // configuration port
    localparam int unsigned CFG_AW = 3;
    localparam int unsigned CFG_DW = 16;

    localparam logic [CFG_AW-1:0] CFG_ENTER_WIN   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ENTER_LVL   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_EXIT_WIN    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_FORCED_WIN  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_EXIT_LVL    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_STALL_MUTEX = 3'd5;

    localparam logic [15:0] RST_ENTER_WIN  = 16'd200;
    localparam logic [15:0] RST_ENTER_LVL  = 16'd1;
    localparam logic [15:0] RST_EXIT_WIN   = 16'd1500;
    localparam logic [15:0] RST_FORCED_WIN = 16'd1000;
    localparam logic [15:0] RST_EXIT_LVL   = 16'd0;

    // event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;

    localparam logic [31:0] FEW_TOGGLES = 32'd10;
    localparam logic [6:0]  PCT_MAX     = 7'd100;
    localparam logic [6:0]  PCT_SCALE   = 7'd100;
    localparam logic [15:0] QUIET_MAX   = 16'hFFFF;
    localparam logic [10:0] LIMIT_DIV   = 11'd2000;

    // quotient is below 100, so seven restoring steps suffice
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned DIV_CNT_W = 3;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_CMP,
        ST_UPD,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic diff;
        logic cmp;
        logic update;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
    } t_dp_sts;

    // magnitude of a 32-bit two's complement difference
    function automatic logic [31:0] mag32(input logic [31:0] d);
        mag32 = d[31] ? (~d + 32'd1) : d;
    endfunction

endpackage

// ----- design/dbed_ctrl.sv -----
module dbed_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output dbed_pkg::t_dp_cmd  o_cmd,
    input  dbed_pkg::t_dp_sts  i_sts
);

    dbed_pkg::t_state r_state, n_state;
    logic [dbed_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic r_out_valid;
    logic slot_free;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dbed_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            dbed_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = dbed_pkg::ST_DIFF;
            end
            dbed_pkg::ST_DIFF: n_state = dbed_pkg::ST_CMP;
            dbed_pkg::ST_CMP:  n_state = dbed_pkg::ST_UPD;
            dbed_pkg::ST_UPD: begin
                n_cnt   = '0;
                n_state = i_sts.need_div ? dbed_pkg::ST_DIV : dbed_pkg::ST_OUT;
            end
            dbed_pkg::ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == dbed_pkg::DIV_LAST) n_state = dbed_pkg::ST_OUT;
            end
            dbed_pkg::ST_OUT: begin
                if (slot_free) n_state = dbed_pkg::ST_IDLE;
            end
            default: n_state = dbed_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_in  = (r_state == dbed_pkg::ST_IDLE) && i_in_valid;
        o_cmd.diff     = (r_state == dbed_pkg::ST_DIFF);
        o_cmd.cmp      = (r_state == dbed_pkg::ST_CMP);
        o_cmd.update   = (r_state == dbed_pkg::ST_UPD);
        o_cmd.div_step = (r_state == dbed_pkg::ST_DIV);
        o_cmd.out_load = (r_state == dbed_pkg::ST_OUT) && slot_free;
    end

    assign o_in_stall = (r_state != dbed_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- design/dbed_dp.sv -----
module dbed_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dbed_pkg::t_dp_cmd             i_cmd,
    output dbed_pkg::t_dp_sts             o_sts,
    input  logic                          i_cfg_we,
    input  logic [dbed_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [dbed_pkg::CFG_DW-1:0]   i_cfg_wdata,
    input  logic [31:0]                   i_now_ms,
    input  logic [31:0]                   i_error_frames,
    input  logic [31:0]                   i_shown_frames,
    input  logic [31:0]                   i_decoded_frames,
    input  logic [7:0]                    i_frame_rate,
    input  logic                          i_stall_active,
    output logic [1:0]                    o_event_res,
    output logic                          o_blur_active,
    output logic [6:0]                    o_error_percent,
    output logic [15:0]                   o_quiet_ms,
    output logic [31:0]                   o_event_time_ms
);

    // configuration
    logic [15:0] r_enter_win, r_enter_lvl, r_exit_win, r_forced_win, r_exit_lvl;
    logic        r_stall_mutex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enter_win   <= dbed_pkg::RST_ENTER_WIN;
            r_enter_lvl   <= dbed_pkg::RST_ENTER_LVL;
            r_exit_win    <= dbed_pkg::RST_EXIT_WIN;
            r_forced_win  <= dbed_pkg::RST_FORCED_WIN;
            r_exit_lvl    <= dbed_pkg::RST_EXIT_LVL;
            r_stall_mutex <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                dbed_pkg::CFG_ENTER_WIN:   r_enter_win   <= i_cfg_wdata;
                dbed_pkg::CFG_ENTER_LVL:   r_enter_lvl   <= i_cfg_wdata;
                dbed_pkg::CFG_EXIT_WIN:    r_exit_win    <= i_cfg_wdata;
                dbed_pkg::CFG_FORCED_WIN:  r_forced_win  <= i_cfg_wdata;
                dbed_pkg::CFG_EXIT_LVL:    r_exit_lvl    <= i_cfg_wdata;
                dbed_pkg::CFG_STALL_MUTEX: r_stall_mutex <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // captured poll
    logic [31:0] r_now, r_errs, r_shown, r_dec;
    logic [7:0]  r_fps;
    logic        r_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_now   <= i_now_ms;
            r_errs  <= i_error_frames;
            r_shown <= i_shown_frames;
            r_dec   <= i_decoded_frames;
            r_fps   <= i_frame_rate;
            r_stall <= i_stall_active;
        end
    end

    // detector state
    logic        r_blur, r_judging, r_force;
    logic [31:0] r_last, r_wse, r_wss, r_wst, r_efe, r_esd;

    // first stage: differences and rate product
    logic [31:0] r_el, r_rise_err, r_rise_shown, r_err_mag, r_tot;
    logic [23:0] r_limit_p;
    logic        r_few, r_chg;

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_el         <= r_now - r_wst;
            r_rise_err   <= r_errs - r_wse;
            r_rise_shown <= r_shown - r_wss;
            r_err_mag    <= dbed_pkg::mag32(r_errs - r_efe);
            r_tot        <= dbed_pkg::mag32(r_dec - r_esd);
            r_limit_p    <= 24'(r_fps) * 24'(r_exit_win);
            r_few        <= (r_shown <= dbed_pkg::FEW_TOGGLES);
            r_chg        <= (r_errs != r_last);
        end
    end

    // second stage: decision flags
    logic        r_f_enter_el, r_f_enter_rise, r_f_exit_el, r_f_forced_el;
    logic        r_f_exit_rise, r_f_shown_ok, r_f_tot_zero, r_f_big;
    logic [38:0] r_n;
    logic [15:0] r_quiet;
    logic [14:0] shown_p1;
    logic [25:0] shown_prod;

    // rise >= floor(P/2000) <=> rise >= 0 and 2000*(rise+1) > P; P < 2^24
    assign shown_p1   = {1'b0, r_rise_shown[13:0]} + 15'd1;
    assign shown_prod = 26'(shown_p1) * 26'(dbed_pkg::LIMIT_DIV);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_f_enter_el   <= (r_el >= 32'(r_enter_win));
            r_f_exit_el    <= (r_el >= 32'(r_exit_win));
            r_f_forced_el  <= (r_el >= 32'(r_forced_win));
            r_f_enter_rise <= ($signed({r_rise_err[31], r_rise_err})
                               >= $signed({17'd0, r_enter_lvl}));
            r_f_exit_rise  <= ($signed({r_rise_err[31], r_rise_err})
                               <= $signed({17'd0, r_exit_lvl}));
            r_f_shown_ok   <= !r_rise_shown[31] &&
                              ((|r_rise_shown[30:14]) || (shown_prod > 26'(r_limit_p)));
            r_f_tot_zero   <= (r_tot == '0);
            r_f_big        <= (r_err_mag >= r_tot);
            r_n            <= 39'(r_err_mag) * 39'(dbed_pkg::PCT_SCALE);
            r_quiet        <= (|r_el[31:16]) ? dbed_pkg::QUIET_MAX : r_el[15:0];
        end
    end

    // state update
    logic        n_blur, n_judging, n_force;
    logic [31:0] n_last, n_wse, n_wss, n_wst, n_efe, n_esd;
    logic [1:0]  n_ev;
    logic [31:0] n_etime;
    logic [15:0] n_quiet;
    logic [6:0]  n_pct;
    logic        ended;

    always_comb begin
        n_blur    = r_blur;
        n_judging = r_judging;
        n_force   = r_force;
        n_last    = r_last;
        n_wse     = r_wse;
        n_wss     = r_wss;
        n_wst     = r_wst;
        n_efe     = r_efe;
        n_esd     = r_esd;
        n_ev      = dbed_pkg::EV_NONE;
        n_etime   = '0;
        n_quiet   = '0;
        n_pct     = '0;
        ended     = 1'b0;
        if (r_few) begin
            n_last = r_errs;
        end else if (!r_blur) begin
            if (!r_judging) begin
                if (r_chg || r_force) begin
                    n_judging = 1'b1;
                    n_wse     = r_last;
                    n_wst     = r_now;
                    n_force   = 1'b0;
                end
            end else if (r_f_enter_el) begin
                n_judging = 1'b0;
                if (r_f_enter_rise) begin
                    n_efe = r_errs;
                    n_wst = r_now;
                    n_esd = r_dec;
                    // stall mutex keeps bookkeeping but suppresses the start
                    if (!(r_stall_mutex && r_stall)) begin
                        n_blur  = 1'b1;
                        n_ev    = dbed_pkg::EV_START;
                        n_etime = r_now;
                    end
                end
            end
            n_last = r_errs;
        end else begin
            if (!r_judging) begin
                if (!r_chg) begin
                    n_judging = 1'b1;
                    n_wse     = r_errs;
                    n_wst     = r_now;
                    n_wss     = r_shown;
                end
            end else if (r_f_exit_el) begin
                n_judging = 1'b0;
                ended     = r_f_exit_rise && r_f_shown_ok;
            end else if (r_chg) begin
                if (r_f_forced_el) begin
                    n_force = 1'b1;
                    ended   = 1'b1;
                end
                n_judging = 1'b0;
            end
            if (ended) begin
                n_blur  = 1'b0;
                n_ev    = dbed_pkg::EV_END;
                n_etime = r_now;
                n_quiet = r_quiet;
                if (!r_f_tot_zero && r_f_big) n_pct = dbed_pkg::PCT_MAX;
            end
            n_last = r_errs;
        end
    end

    assign o_sts.need_div = ended && !r_f_tot_zero && !r_f_big;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blur    <= 1'b0;
            r_judging <= 1'b0;
            r_force   <= 1'b0;
            r_last    <= '0;
            r_wse     <= '0;
            r_wss     <= '0;
            r_wst     <= '0;
            r_efe     <= '0;
            r_esd     <= '0;
        end else if (i_cmd.update) begin
            r_blur    <= n_blur;
            r_judging <= n_judging;
            r_force   <= n_force;
            r_last    <= n_last;
            r_wse     <= n_wse;
            r_wss     <= n_wss;
            r_wst     <= n_wst;
            r_efe     <= n_efe;
            r_esd     <= n_esd;
        end
    end

    // pending result and restoring divider for the percentage
    logic [1:0]  r_res_ev;
    logic        r_res_blur;
    logic [6:0]  r_res_pct;
    logic [15:0] r_res_quiet;
    logic [31:0] r_res_etime;
    logic [38:0] r_rem, r_dsh;
    logic        div_ge;

    assign div_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_res_ev    <= n_ev;
            r_res_blur  <= n_blur;
            r_res_pct   <= n_pct;
            r_res_quiet <= n_quiet;
            r_res_etime <= n_etime;
            r_rem       <= r_n;
            r_dsh       <= {1'b0, r_tot, 6'd0};
        end else if (i_cmd.div_step) begin
            if (div_ge) r_rem <= r_rem - r_dsh;
            r_dsh     <= r_dsh >> 1;
            r_res_pct <= {r_res_pct[dbed_pkg::PCT_W-2:0], div_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_event_res     <= r_res_ev;
            o_blur_active   <= r_res_blur;
            o_error_percent <= r_res_pct;
            o_quiet_ms      <= r_res_quiet;
            o_event_time_ms <= r_res_etime;
        end
    end

endmodule

// ----- design/debounced_blur_episode_detector_core.sv -----
// Debounced blur episode detector. Each accepted poll (time, error/shown/decoded
// frame counters, frame rate, stall flag) yields exactly one result transfer with
// the event code (none, blur started, blur ended), the blur state after the poll
// and, on an end event, the error percentage and the saturated quiet time. The
// result passes through the difference, compare and update states into the output
// register, and also through the divide state when an episode ends with a nonzero
// decoded rise larger than the error rise, since the percentage then runs through
// a 7-step restoring divider. Polls are worked one at a time; the input stalls
// until the previous result is in the output register, which holds it while the
// downstream side stalls. Configuration writes go through the plain write port and
// must only happen while no poll is in flight.
module debounced_blur_episode_detector_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dbed_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [dbed_pkg::CFG_DW-1:0]   i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [31:0]                   i_now_ms,
    input  logic [31:0]                   i_error_frames,
    input  logic [31:0]                   i_shown_frames,
    input  logic [31:0]                   i_decoded_frames,
    input  logic [7:0]                    i_frame_rate,
    input  logic                          i_stall_active,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_event_res,
    output logic                          o_blur_active,
    output logic [6:0]                    o_error_percent,
    output logic [15:0]                   o_quiet_ms,
    output logic [31:0]                   o_event_time_ms
);

    dbed_pkg::t_dp_cmd cmd;
    dbed_pkg::t_dp_sts sts;

    dbed_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    dbed_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_now_ms         (i_now_ms),
        .i_error_frames   (i_error_frames),
        .i_shown_frames   (i_shown_frames),
        .i_decoded_frames (i_decoded_frames),
        .i_frame_rate     (i_frame_rate),
        .i_stall_active   (i_stall_active),
        .o_event_res      (o_event_res),
        .o_blur_active    (o_blur_active),
        .o_error_percent  (o_error_percent),
        .o_quiet_ms       (o_quiet_ms),
        .o_event_time_ms  (o_event_time_ms)
    );

    // one poll in flight: a transfer closes the input next cycle
    a_single_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after a transfer");

    a_event_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == dbed_pkg::EV_START || o_event_res == dbed_pkg::EV_END)
        |-> (o_blur_active == (o_event_res == dbed_pkg::EV_START)))
        else $error("event code disagrees with blur state");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_error_percent <= dbed_pkg::PCT_MAX))
        else $error("error percentage above limit");

    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_res == dbed_pkg::EV_NONE
        |-> (o_event_time_ms == '0 && o_quiet_ms == '0 && o_error_percent == '0))
        else $error("no-event result carries event data");

endmodule
